>>> hdl/deque_with_search_assert.svh
// Assertion macros used by the deque top level.
`ifndef DEQUE_WITH_SEARCH_ASSERT_SVH
`define DEQUE_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define DQS_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("deque check failed");

// Next-cycle implication, disabled while reset is low.
`define DQS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("deque check failed");

`endif

>>> hdl/dqs_pkg.sv
// Types, constants and helpers shared by the deque controller and datapath.
package dqs_pkg;

    localparam int DEPTH    = 64;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = CNT_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // latch the accepted item
        logic exec;    // carry out the request
        logic search;  // advance the search walk by one entry
        logic emit;    // move the result into the output register
    } t_dqs_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic search_go;   // request is a search on a non-empty deque
        logic search_hit;  // the pending entry matches
        logic search_miss; // walk finished with no match
    } t_dqs_sts;

    // Ring slot at base + offset, offset below twice the depth minus base
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offset);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, offset};
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Ring slot just in front of base
    function automatic logic [IDX_W-1:0] slot_before(input logic [IDX_W-1:0] base);
        logic [IDX_W-1:0] prev;
        if (base == '0) begin
            prev = IDX_W'(DEPTH - 1);
        end else begin
            prev = base - 1'b1;
        end
        return prev;
    endfunction

endpackage

>>> hdl/deque_with_search.sv
// Top level of the bounded deque with front-to-back search.
//
// A bounded double-ended queue of 64 signed 32-bit values held in a ring RAM
// with a front pointer and a count. Each request item on the slave stream
// (opcode in tuser, value in tdata) gives exactly one result item on the
// master stream: status, 1-based match position and the count afterwards.
// One request is worked on at a time. Pushes, pops and unused opcodes pass
// through accept, execute and hand-off to the result register. A search on a
// non-empty deque walks the stored entries from the front: it reads one stored
// entry per cycle through the single read port of the ring RAM, compares it in
// the next cycle and stops at the first match or after the last entry. A result
// may wait in the output register while the next request is accepted. The RAM
// is not cleared; no entry is read before it is written.
module deque_with_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] value
    input  logic [2:0]  i_s_axis_tuser,  // [2:0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata   // [1:0] status, [8:2] position, [15:9] count
);

    `include "deque_with_search_assert.svh"

    dqs_pkg::t_dqs_cmd                 cmd;
    dqs_pkg::t_dqs_sts                 sts;
    logic [dqs_pkg::STATUS_W-1:0]      status;
    logic [dqs_pkg::POS_W-1:0]         position;
    logic [dqs_pkg::CNT_W-1:0]         count;
    logic                              in_accept;

    dqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    dqs_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_opcode   (i_s_axis_tuser),
        .i_value    (i_s_axis_tdata),
        .o_status   (status),
        .o_position (position),
        .o_count    (count)
    );

    // Pack the result fields
    assign o_m_axis_tdata = {count, position, status};

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    // Only one command is active per cycle
    `DQS_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd))
    // An accepted item is executed in the next cycle
    `DQS_ASSERT_NEXT(a_accept_exec, in_accept, cmd.exec)
    // A full status only comes with a full count
    `DQS_ASSERT_NOW(a_full_count, o_m_axis_tvalid && (status == dqs_pkg::ST_FULL),
                    count == dqs_pkg::CNT_W'(dqs_pkg::DEPTH))
    // A match position never exceeds the count
    `DQS_ASSERT_NOW(a_pos_range, o_m_axis_tvalid, position <= count)

endmodule

>>> hdl/dqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/dqs_ctrl.sv
// Request sequencer for the deque: accept, execute, search walk, result hand-off.
module dqs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dqs_pkg::t_dqs_cmd o_cmd,
    input  dqs_pkg::t_dqs_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    // Decode commands from the current state
    always_comb begin
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE:   o_cmd.load   = i_in_valid;
            S_EXEC:   o_cmd.exec   = 1'b1;
            S_SEARCH: o_cmd.search = 1'b1;
            S_FINISH: o_cmd.emit   = !r_out_valid || i_out_ready;
            default:  o_cmd        = '0;
        endcase
    end

    // Advance state and hold the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= i_sts.search_go ? S_SEARCH : S_FINISH;
                end
                S_SEARCH: begin
                    if (i_sts.search_hit || i_sts.search_miss) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (o_cmd.emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/dqs_datapath.sv
// Deque datapath: ring RAM, front pointer, count, search walk and result registers.
module dqs_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dqs_pkg::t_dqs_cmd                   i_cmd,
    output dqs_pkg::t_dqs_sts                   o_sts,
    input  logic [dqs_pkg::OPCODE_W-1:0]        i_opcode,
    input  logic signed [dqs_pkg::VALUE_W-1:0]  i_value,
    output logic [dqs_pkg::STATUS_W-1:0]        o_status,
    output logic [dqs_pkg::POS_W-1:0]           o_position,
    output logic [dqs_pkg::CNT_W-1:0]           o_count
);

    dqs_pkg::t_opcode                   r_op;
    logic signed [dqs_pkg::VALUE_W-1:0] r_val;
    logic [dqs_pkg::IDX_W-1:0]          r_front;
    logic [dqs_pkg::CNT_W-1:0]          r_count;
    logic [dqs_pkg::CNT_W-1:0]          r_issue;
    logic                               r_pend;
    logic [dqs_pkg::IDX_W-1:0]          r_pend_idx;
    dqs_pkg::t_status                   r_status;
    logic [dqs_pkg::POS_W-1:0]          r_pos;
    logic [dqs_pkg::STATUS_W-1:0]       r_out_status;
    logic [dqs_pkg::POS_W-1:0]          r_out_pos;
    logic [dqs_pkg::CNT_W-1:0]          r_out_count;

    logic                               full;
    logic                               empty;
    logic                               we;
    logic [dqs_pkg::IDX_W-1:0]          waddr;
    logic [dqs_pkg::IDX_W-1:0]          raddr;
    logic signed [dqs_pkg::VALUE_W-1:0] rdata;
    logic                               hit;

    assign full  = (r_count == dqs_pkg::CNT_W'(dqs_pkg::DEPTH));
    assign empty = (r_count == '0);

    // Write on a push that has room
    assign we = i_cmd.exec && !full &&
                ((r_op == dqs_pkg::OP_PUSH_FRONT) || (r_op == dqs_pkg::OP_PUSH_BACK));
    assign waddr = (r_op == dqs_pkg::OP_PUSH_FRONT) ? dqs_pkg::slot_before(r_front)
                                                   : dqs_pkg::slot_of(r_front, r_count);
    assign raddr = dqs_pkg::slot_of(r_front, r_issue);

    dqs_ram #(
        .WIDTH (dqs_pkg::VALUE_W),
        .DEPTH (dqs_pkg::DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_val),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign hit = r_pend && (rdata == r_val);

    assign o_sts.search_go   = (r_op == dqs_pkg::OP_SEARCH) && !empty;
    assign o_sts.search_hit  = hit;
    assign o_sts.search_miss = !r_pend && (r_issue == r_count);

    // Hold the deque pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            case (r_op)
                dqs_pkg::OP_PUSH_FRONT: begin
                    if (!full) begin
                        r_front <= dqs_pkg::slot_before(r_front);
                        r_count <= r_count + 1'b1;
                    end
                end
                dqs_pkg::OP_PUSH_BACK: begin
                    if (!full) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                dqs_pkg::OP_POP_FRONT: begin
                    if (!empty) begin
                        r_front <= dqs_pkg::slot_of(r_front, dqs_pkg::CNT_W'(1));
                        r_count <= r_count - 1'b1;
                    end
                end
                dqs_pkg::OP_POP_BACK: begin
                    if (!empty) begin
                        r_count <= r_count - 1'b1;
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // Latch the item, set the result, walk the search
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_op  <= dqs_pkg::t_opcode'(i_opcode);
                r_val <= i_value;
            end

            if (i_cmd.exec) begin
                r_pos   <= '0;
                r_issue <= '0;
                r_pend  <= 1'b0;
                case (r_op)
                    dqs_pkg::OP_PUSH_FRONT,
                    dqs_pkg::OP_PUSH_BACK: begin
                        r_status <= full ? dqs_pkg::ST_FULL : dqs_pkg::ST_OK;
                    end
                    dqs_pkg::OP_POP_FRONT,
                    dqs_pkg::OP_POP_BACK: begin
                        r_status <= empty ? dqs_pkg::ST_EMPTY : dqs_pkg::ST_OK;
                    end
                    dqs_pkg::OP_SEARCH: begin
                        r_status <= empty ? dqs_pkg::ST_EMPTY : dqs_pkg::ST_NOTFOUND;
                    end
                    default: begin
                        r_status <= dqs_pkg::ST_OK;
                    end
                endcase
            end

            // Issue one read a cycle and compare the entry read last cycle
            if (i_cmd.search) begin
                if (r_issue < r_count) begin
                    r_issue    <= r_issue + 1'b1;
                    r_pend     <= 1'b1;
                    r_pend_idx <= r_issue[dqs_pkg::IDX_W-1:0];
                end else begin
                    r_pend <= 1'b0;
                end
                if (hit) begin
                    r_status <= dqs_pkg::ST_OK;
                    r_pos    <= dqs_pkg::POS_W'(r_pend_idx) + 1'b1;
                end
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            r_out_pos    <= r_pos;
            r_out_count  <= r_count;
        end
    end

    assign o_status   = r_out_status;
    assign o_position = r_out_pos;
    assign o_count    = r_out_count;

endmodule

>>> tb/deque_with_search_tb.sv
// Self-checking testbench for the bounded deque with front-to-back search.
module deque_with_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          DRAIN_CYCLES    = 80;
    localparam int          RANDOM_ITEMS    = 310;
    localparam int          MAX_PRINTED     = 20;
    localparam logic [2:0]  OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0]  OP_LAST_UNUSED  = 3'd7;

    typedef enum int { PH_FILL, PH_DRAIN, PH_MIXED } t_phase;

    // One result item as the block returns it
    typedef struct packed {
        dqs_pkg::t_status                status;
        logic [dqs_pkg::POS_W-1:0]       position;
        logic [dqs_pkg::CNT_W-1:0]       count;
    } t_result;

    // Mirror of the deque plus the queue of results still owed by the block
    class deque_scoreboard;
        logic [dqs_pkg::VALUE_W-1:0] ring [dqs_pkg::DEPTH];
        int unsigned        front_idx;
        int unsigned        n_stored;
        t_result            expected_results[$];
        int                 errors;
        int                 n_requests;
        int                 status_seen [4];
        int                 peak_fill;

        function int unsigned slot(int unsigned offset);
            return (front_idx + offset) % dqs_pkg::DEPTH;
        endfunction

        function logic [dqs_pkg::VALUE_W-1:0] stored_at(int unsigned offset);
            return ring[slot(offset)];
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            end
        endtask

        // Apply one accepted request and queue the result it owes
        task note_request(logic [dqs_pkg::OPCODE_W-1:0] op,
                          logic [dqs_pkg::VALUE_W-1:0] val);
            t_result r;
            r.status   = dqs_pkg::ST_OK;
            r.position = '0;
            n_requests++;
            case (op)
                dqs_pkg::OP_PUSH_FRONT, dqs_pkg::OP_PUSH_BACK: begin
                    if (n_stored >= dqs_pkg::DEPTH) begin
                        r.status = dqs_pkg::ST_FULL;
                    end else if (op == dqs_pkg::OP_PUSH_FRONT) begin
                        front_idx = (front_idx + dqs_pkg::DEPTH - 1) % dqs_pkg::DEPTH;
                        ring[front_idx] = val;
                        n_stored++;
                    end else begin
                        ring[slot(n_stored)] = val;
                        n_stored++;
                    end
                end
                dqs_pkg::OP_POP_FRONT, dqs_pkg::OP_POP_BACK: begin
                    if (n_stored == 0) begin
                        r.status = dqs_pkg::ST_EMPTY;
                    end else begin
                        if (op == dqs_pkg::OP_POP_FRONT) begin
                            front_idx = slot(1);
                        end
                        n_stored--;
                    end
                end
                dqs_pkg::OP_SEARCH: begin
                    if (n_stored == 0) begin
                        r.status = dqs_pkg::ST_EMPTY;
                    end else begin
                        r.status = dqs_pkg::ST_NOTFOUND;
                        for (int i = 0; i < n_stored; i++) begin
                            if (stored_at(i) == val) begin
                                r.status   = dqs_pkg::ST_OK;
                                r.position = dqs_pkg::POS_W'(i + 1);
                                break;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            r.count = dqs_pkg::CNT_W'(n_stored);
            if (n_stored > peak_fill) begin
                peak_fill = n_stored;
            end
            status_seen[r.status]++;
            expected_results.push_back(r);
        endtask

        // Compare one result item with the oldest owed result
        task check_result(logic [dqs_pkg::STATUS_W-1:0] st, logic [dqs_pkg::POS_W-1:0] pos,
                          logic [dqs_pkg::CNT_W-1:0] cnt);
            t_result want;
            if (expected_results.size() == 0) begin
                report_mismatch("result item with no request outstanding");
            end else begin
                want = expected_results.pop_front();
                if (st !== want.status) begin
                    report_mismatch($sformatf("status %0d, want %0d", st, want.status));
                end
                if (pos !== want.position) begin
                    report_mismatch($sformatf("position %0d, want %0d", pos, want.position));
                end
                if (cnt !== want.count) begin
                    report_mismatch($sformatf("count %0d, want %0d", cnt, want.count));
                end
            end
        endtask

        // Flag results that never came back
        task wrap_up();
            if (expected_results.size() != 0) begin
                report_mismatch($sformatf("%0d results never arrived",
                                          expected_results.size()));
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [31:0]         i_s_axis_tdata;   // [31:0] value
    logic [2:0]          i_s_axis_tuser;   // [2:0] opcode
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [15:0]         o_m_axis_tdata;   // [1:0] status, [8:2] position, [15:9] count

    deque_scoreboard              sb = new();
    int                           n_accepted;
    int                           n_sent;
    int                           burst_left;
    int                           cycle_cnt;
    logic [dqs_pkg::VALUE_W-1:0]  value_pool [8];

    deque_with_search i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Observe both handshakes on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sb.note_request(i_s_axis_tuser, i_s_axis_tdata);
                n_accepted <= n_accepted + 1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_result(o_m_axis_tdata[1:0], o_m_axis_tdata[8:2],
                                o_m_axis_tdata[15:9]);
            end
        end
    end

    // Result-side backpressure: stretches of full speed, random drops, long stalls
    initial begin : result_stall
        int mode;
        int mode_left;
        int stall_left;
        mode       = 0;
        mode_left  = 0;
        stall_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 200);
            end
            mode_left--;
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready = 1'b0;
            end else if (mode == 0) begin
                i_m_axis_tready = 1'b1;
            end else if (mode == 1) begin
                i_m_axis_tready = ($urandom_range(0, 99) < 70);
            end else begin
                if ($urandom_range(0, 99) < 10) begin
                    stall_left = $urandom_range(1, 30);
                end
                i_m_axis_tready = (stall_left == 0);
            end
        end
    end

    // Offer one request item in the current burst; return at the falling edge after acceptance
    task automatic send_request(logic [dqs_pkg::OPCODE_W-1:0] op,
                                logic [dqs_pkg::VALUE_W-1:0] val);
        int seen;
        if (burst_left == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 99) < 15 ? $urandom_range(9, 20)
                                               : $urandom_range(1, 8)) begin
                @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 99) < 10) ? $urandom_range(60, 120)
                                                      : $urandom_range(1, 12);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = op;
        i_s_axis_tdata  = val;
        seen = n_accepted;
        do @(negedge i_clk); while (n_accepted == seen);
        burst_left--;
        n_sent++;
    endtask

    // Mix of wide random values, repeated values, small values and the signed extremes
    function automatic logic [dqs_pkg::VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return $urandom;
        if (sel < 8) return value_pool[$urandom_range(0, 7)];
        if (sel == 8) return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return $urandom_range(0, 3);
    endfunction

    // Search for a stored value most of the time so that hits land everywhere
    function automatic logic [dqs_pkg::VALUE_W-1:0] pick_search_value();
        if (sb.n_stored != 0 && $urandom_range(0, 99) < 60) begin
            return sb.stored_at($urandom_range(0, sb.n_stored - 1));
        end
        return pick_value();
    endfunction

    function automatic logic [dqs_pkg::OPCODE_W-1:0] pick_op(t_phase ph);
        int r;
        int push_share;
        r = $urandom_range(0, 99);
        if (r < 3) return $urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED);
        if (r < 23) return dqs_pkg::OP_SEARCH;
        push_share = (ph == PH_FILL) ? 75 : (ph == PH_DRAIN) ? 20 : 50;
        if ($urandom_range(0, 99) < push_share) begin
            return ($urandom_range(0, 1) != 0) ? dqs_pkg::OP_PUSH_FRONT
                                               : dqs_pkg::OP_PUSH_BACK;
        end
        return ($urandom_range(0, 1) != 0) ? dqs_pkg::OP_POP_FRONT : dqs_pkg::OP_POP_BACK;
    endfunction

    // Send an item with a value suited to its opcode
    task automatic send_random(logic [dqs_pkg::OPCODE_W-1:0] op);
        send_request(op, (op == dqs_pkg::OP_SEARCH) ? pick_search_value() : pick_value());
    endtask

    // Main sequence
    initial begin : stimulus
        t_phase ph;
        int     ph_left;
        int     cycles_waited;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = dqs_pkg::OP_PUSH_FRONT;
        n_accepted      = 0;
        n_sent          = 0;
        burst_left      = 0;
        cycle_cnt       = 0;
        cycles_waited   = 0;
        foreach (value_pool[i]) value_pool[i] = $urandom;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty-deque cases and unused opcodes
        send_request(dqs_pkg::OP_SEARCH, 32'h0);
        send_request(dqs_pkg::OP_POP_FRONT, $urandom);
        send_request(dqs_pkg::OP_POP_BACK, $urandom);
        for (logic [3:0] op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++) begin
            send_request(op[2:0], $urandom);
        end
        // Both ends with the value extremes; push front wraps the front pointer
        send_request(dqs_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_request(dqs_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        send_request(dqs_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_request(dqs_pkg::OP_PUSH_FRONT, 32'h0);
        send_request(dqs_pkg::OP_SEARCH, 32'h8000_0000);
        send_request(dqs_pkg::OP_SEARCH, 32'hFFFF_FFFF);
        send_request(dqs_pkg::OP_SEARCH, 32'h1234_5678);
        send_request(dqs_pkg::OP_PUSH_BACK, 32'h0);
        // Duplicate: first match wins
        send_request(dqs_pkg::OP_SEARCH, 32'h0);
        send_request(dqs_pkg::OP_POP_BACK, $urandom);
        send_request(dqs_pkg::OP_POP_FRONT, $urandom);
        send_request(dqs_pkg::OP_SEARCH, 32'h0);
        send_request(dqs_pkg::OP_POP_FRONT, $urandom);
        send_request(dqs_pkg::OP_POP_BACK, $urandom);
        // Search on a one-entry deque holding the positive extreme
        send_request(dqs_pkg::OP_SEARCH, 32'h7FFF_FFFF);
        send_request(dqs_pkg::OP_POP_BACK, $urandom);

        // Fill to the brim, push past it, then search the full deque
        while (sb.n_stored < dqs_pkg::DEPTH) begin
            send_request(($urandom_range(0, 1) != 0) ? dqs_pkg::OP_PUSH_FRONT
                                                     : dqs_pkg::OP_PUSH_BACK,
                         pick_value());
        end
        send_request(dqs_pkg::OP_PUSH_FRONT, $urandom);
        send_request(dqs_pkg::OP_PUSH_BACK, $urandom);
        send_request(dqs_pkg::OP_SEARCH, sb.stored_at(dqs_pkg::DEPTH - 1));
        send_random(dqs_pkg::OP_SEARCH);

        // Random phases swinging the fill level between empty and full
        ph      = PH_DRAIN;
        ph_left = $urandom_range(60, 120);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (ph_left == 0) begin
                ph      = t_phase'($urandom_range(0, 2));
                ph_left = $urandom_range(30, 120);
            end
            ph_left--;
            send_random(pick_op(ph));
        end
        i_s_axis_tvalid = 1'b0;

        // Let outstanding results drain, then a tail for stray items
        while (sb.expected_results.size() != 0) begin
            @(posedge i_clk);
            cycles_waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.wrap_up();

        $display("Sent %0d requests: %0d ok, %0d full, %0d empty, %0d not-found results",
                 n_sent, sb.status_seen[dqs_pkg::ST_OK], sb.status_seen[dqs_pkg::ST_FULL],
                 sb.status_seen[dqs_pkg::ST_EMPTY], sb.status_seen[dqs_pkg::ST_NOTFOUND]);
        $display("Peak fill %0d of %0d entries, %0d mismatches",
                 sb.peak_fill, dqs_pkg::DEPTH, sb.errors);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/dqs_pkg.sv
hdl/dqs_ram.sv
hdl/dqs_ctrl.sv
hdl/dqs_datapath.sv
hdl/deque_with_search.sv
tb/deque_with_search_tb.sv
